// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/pcagq_pkg.sv =====
package pcagq_pkg;

  localparam int unsigned GLYPH_COUNT_DEF     = 10;
  localparam int unsigned MAX_FRAME_WIDTH_DEF = 4096;
  localparam int unsigned MAX_CELL_SIZE_DEF   = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 3'd4;

  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [4:0]  CELL_WIDTH_RST   = 5'd8;
  localparam logic [4:0]  CELL_HEIGHT_RST  = 5'd16;

  localparam logic [15:0] LUM_R = 16'd19595;
  localparam logic [15:0] LUM_G = 16'd38470;
  localparam logic [15:0] LUM_B = 16'd7471;
  localparam logic [31:0] GLYPH_HALF = 32'd8355840;
  localparam logic [31:0] GLYPH_DEN  = 32'd16711680;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_LUM,
    ST_SCL,
    ST_QDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic acc;
    logic div_step;
    logic lum;
    logic scale;
    logic qdiv_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic qdiv_done;
    logic out_space;
  } sts_t;

endpackage

// ===== rtl/pcagq_ctrl.sv =====
`include "assert_macros.svh"

module pcagq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pcagq_pkg::sts_t sts_i,
  output pcagq_pkg::cmd_t cmd_o
);

  pcagq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcagq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pcagq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pcagq_pkg::ST_ACC;
        end
      end
      pcagq_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.emit ? pcagq_pkg::ST_DIV : pcagq_pkg::ST_IDLE;
      end
      pcagq_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = pcagq_pkg::ST_LUM;
        end
      end
      pcagq_pkg::ST_LUM: begin
        cmd_o.lum = 1'b1;
        state_d   = pcagq_pkg::ST_SCL;
      end
      pcagq_pkg::ST_SCL: begin
        cmd_o.scale = 1'b1;
        state_d     = pcagq_pkg::ST_QDIV;
      end
      pcagq_pkg::ST_QDIV: begin
        cmd_o.qdiv_step = 1'b1;
        if (sts_i.qdiv_done) begin
          state_d = pcagq_pkg::ST_OUT;
        end
      end
      pcagq_pkg::ST_OUT: begin
        if (sts_i.out_space) begin
          cmd_o.load_out = 1'b1;
          state_d        = pcagq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcagq_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_PROP(a_accept_goes_acc, clk_i, rst_ni,
               (state_q == pcagq_pkg::ST_IDLE && in_valid_i) |=> (state_q == pcagq_pkg::ST_ACC))
  `ASSERT_PROP(a_div_done_goes_lum, clk_i, rst_ni,
               (state_q == pcagq_pkg::ST_DIV && sts_i.div_done) |=> (state_q == pcagq_pkg::ST_LUM))
  `ASSERT_NEVER(a_load_without_space, clk_i, rst_ni, cmd_o.load_out && !sts_i.out_space)

endmodule

// ===== rtl/pcagq_datapath.sv =====
module pcagq_datapath #(
  parameter int unsigned GLYPH_COUNT     = pcagq_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned MAX_FRAME_WIDTH = pcagq_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int unsigned MAX_CELL_SIZE   = pcagq_pkg::MAX_CELL_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcagq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pcagq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [pcagq_pkg::IN_DATA_W-1:0]       in_data_i,
  output logic [pcagq_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                  out_has_bg_o,
  output logic                                  out_last_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  pcagq_pkg::cmd_t                       cmd_i,
  output pcagq_pkg::sts_t                       sts_o
);

  localparam int unsigned MAXW  = (MAX_FRAME_WIDTH < 4096) ? MAX_FRAME_WIDTH : 4096;
  localparam int unsigned AW    = $clog2(MAX_FRAME_WIDTH);
  localparam int unsigned CSW   = $clog2(MAX_CELL_SIZE + 1);
  localparam int unsigned CNTW  = 2 * CSW;
  localparam int unsigned SW    = 8 + CNTW;
  localparam int unsigned DCW   = $clog2(SW);
  localparam int unsigned GM1   = GLYPH_COUNT - 1;
  localparam logic [12:0] MAXW_V = 13'(MAXW);
  localparam logic [5:0]  MAXC_V = 6'((MAX_CELL_SIZE > 31) ? 31 : MAX_CELL_SIZE);

  // configuration
  logic [12:0] fw_reg_q, fh_reg_q;
  logic [4:0]  cw_reg_q, ch_reg_q;
  logic        color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_reg_q <= pcagq_pkg::FRAME_WIDTH_RST;
      fh_reg_q <= pcagq_pkg::FRAME_HEIGHT_RST;
      cw_reg_q <= pcagq_pkg::CELL_WIDTH_RST;
      ch_reg_q <= pcagq_pkg::CELL_HEIGHT_RST;
      color_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcagq_pkg::REG_FRAME_WIDTH:  fw_reg_q <= cfg_data_i;
        pcagq_pkg::REG_FRAME_HEIGHT: fh_reg_q <= cfg_data_i;
        pcagq_pkg::REG_CELL_WIDTH:   cw_reg_q <= cfg_data_i[4:0];
        pcagq_pkg::REG_CELL_HEIGHT:  ch_reg_q <= cfg_data_i[4:0];
        pcagq_pkg::REG_COLOR_MODE:   color_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic        restart;
  logic [12:0] fw, fh;
  logic [5:0]  cw, ch;

  always_comb begin
    restart = cfg_we_i && (cfg_idx_i <= pcagq_pkg::REG_COLOR_MODE);
    fw = (fw_reg_q == 13'd0) ? 13'd1 : ((fw_reg_q > MAXW_V) ? MAXW_V : fw_reg_q);
    fh = (fh_reg_q == 13'd0) ? 13'd1 : ((fh_reg_q > 13'd4096) ? 13'd4096 : fh_reg_q);
    cw = (cw_reg_q == 5'd0) ? 6'd1 : (({1'b0, cw_reg_q} > MAXC_V) ? MAXC_V : {1'b0, cw_reg_q});
    ch = (ch_reg_q == 5'd0) ? 6'd1 : (({1'b0, ch_reg_q} > MAXC_V) ? MAXC_V : {1'b0, ch_reg_q});
  end

  // position counters
  logic [11:0]    px_q, py_q, band_q;
  logic [CSW-1:0] xc_q, yc_q;
  logic [AW-1:0]  col_q;

  logic end_x, end_y, last_x, last_y;

  always_comb begin
    end_x  = {1'b0, px_q} >= (fw - 13'd1);
    end_y  = {1'b0, py_q} >= (fh - 13'd1);
    last_x = (6'(xc_q) >= (cw - 6'd1)) || end_x;
    last_y = (6'(yc_q) >= (ch - 6'd1)) || end_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      band_q <= '0;
      xc_q   <= '0;
      yc_q   <= '0;
      col_q  <= '0;
    end else if (restart) begin
      px_q   <= '0;
      py_q   <= '0;
      band_q <= '0;
      xc_q   <= '0;
      yc_q   <= '0;
      col_q  <= '0;
    end else if (cmd_i.capture) begin
      if (end_x) begin
        px_q  <= '0;
        xc_q  <= '0;
        col_q <= '0;
        if (end_y) begin
          py_q   <= '0;
          yc_q   <= '0;
          band_q <= '0;
        end else begin
          py_q <= py_q + 12'd1;
          if (last_y) begin
            yc_q   <= '0;
            band_q <= band_q + 12'd1;
          end else begin
            yc_q <= yc_q + CSW'(1);
          end
        end
      end else begin
        px_q <= px_q + 12'd1;
        if (last_x) begin
          xc_q  <= '0;
          col_q <= col_q + AW'(1);
        end else begin
          xc_q <= xc_q + CSW'(1);
        end
      end
    end
  end

  // captured item
  logic [7:0]      pix_q [3];
  logic [AW-1:0]   cur_col_q;
  logic [11:0]     cur_row_q;
  logic [CNTW-1:0] count_q;
  logic            emit_q, first_q, frame_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q[0]    <= in_data_i[7:0];
      pix_q[1]    <= in_data_i[15:8];
      pix_q[2]    <= in_data_i[23:16];
      cur_col_q   <= col_q;
      cur_row_q   <= band_q;
      count_q     <= CNTW'((CNTW'(xc_q) + CNTW'(1)) * (CNTW'(yc_q) + CNTW'(1)));
      emit_q      <= last_x && last_y;
      first_q     <= (xc_q == '0) && (yc_q == '0);
      frame_end_q <= end_x && end_y;
    end
  end

  // column sums, read at accept, written back in the next cycle unless the pixel closes a cell
  logic [3*SW-1:0] sum_mem [MAX_FRAME_WIDTH];
  logic [3*SW-1:0] rd_q;
  logic [SW-1:0]   sum_new [3];

  always_ff @(posedge clk_i) begin
    rd_q <= sum_mem[col_q];
    if (cmd_i.acc && !emit_q) begin
      sum_mem[cur_col_q] <= {sum_new[2], sum_new[1], sum_new[0]};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_new[c] = (first_q ? SW'(0) : rd_q[c*SW +: SW]) + SW'(pix_q[c]);
    end
  end

  // averages by restoring division
  logic [SW-1:0]   quo_q [3];
  logic [CNTW-1:0] rem_q [3];
  logic [DCW-1:0]  dcnt_q;
  logic [CNTW:0]   rem_sh [3];
  logic [CNTW:0]   rem_sub [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c]  = {rem_q[c], quo_q[c][SW-1]};
      rem_sub[c] = rem_sh[c] - {1'b0, count_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      for (int c = 0; c < 3; c++) begin
        quo_q[c] <= sum_new[c];
        rem_q[c] <= '0;
      end
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_sh[c] >= {1'b0, count_q}) begin
          rem_q[c] <= rem_sub[c][CNTW-1:0];
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b1};
        end else begin
          rem_q[c] <= rem_sh[c][CNTW-1:0];
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b0};
        end
      end
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  // luminance and glyph index
  logic [23:0] y16_q;
  logic [31:0] num_q;
  logic [7:0]  q_q;
  logic [31:0] recip;

  // divide by 255 * 65536: drop the low 16 bits, then multiply by 2^23 / 255 rounded up
  assign recip = 32'(num_q[31:16]) * 32'd32897;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lum) begin
      y16_q <= 24'(pcagq_pkg::LUM_R) * 24'(quo_q[0][7:0])
             + 24'(pcagq_pkg::LUM_G) * 24'(quo_q[1][7:0])
             + 24'(pcagq_pkg::LUM_B) * 24'(quo_q[2][7:0]);
    end
    if (cmd_i.scale) begin
      num_q <= 32'(y16_q) * 32'(GM1) + pcagq_pkg::GLYPH_HALF;
    end
    if (cmd_i.qdiv_step) begin
      q_q <= recip[30:23];
    end
  end

  logic [7:0] glyph;
  assign glyph = (q_q > 8'(GM1)) ? 8'(GM1) : q_q;

  // result register
  localparam int unsigned OUT_DATA_W_L = pcagq_pkg::OUT_DATA_W;
  logic [OUT_DATA_W_L-1:0] out_q;
  logic out_has_bg_q, out_last_q, out_valid_q;
  logic [7:0] fg [3];
  logic [7:0] bg [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fg[c] = color_q ? quo_q[c][7:0] : 8'hff;
      bg[c] = color_q ? {2'b00, quo_q[c][7:2]} : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {bg[2], bg[1], bg[0], fg[2], fg[1], fg[0], glyph, cur_row_q,
                12'(cur_col_q)};
      out_has_bg_q <= color_q;
      out_last_q   <= frame_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_data_o   = out_q;
  assign out_has_bg_o = out_has_bg_q;
  assign out_last_o   = out_last_q;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    sts_o.emit      = emit_q;
    sts_o.div_done  = (dcnt_q == DCW'(SW - 1));
    sts_o.qdiv_done = 1'b1;
    sts_o.out_space = !out_valid_q || out_ready_i;
  end

endmodule

// ===== rtl/pixel_cell_average_glyph_quantizer.sv =====
// Box-downsampling glyph quantizer: takes one RGB pixel per item in raster order, sums each
// cell column over a band of cell rows in a column sum memory and emits one cell item
// when the last pixel of a cell arrives (average colour, glyph index, frame_done on tlast).
// A pixel that does not close a cell is accepted, then its column sum is read, modified and
// written back. A closing pixel then goes through the bit-serial average divider, luminance,
// scaling and the glyph quotient before its cell item is loaded; it waits for that load while
// the previous cell sits unread in the output register; no new pixel is taken meanwhile.
// A write to registers 0 to 4 restarts the frame; no clearing pass is needed after reset.
module pixel_cell_average_glyph_quantizer #(
  parameter int unsigned GLYPH_COUNT     = pcagq_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned MAX_FRAME_WIDTH = pcagq_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int unsigned MAX_CELL_SIZE   = pcagq_pkg::MAX_CELL_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcagq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pcagq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_red, pixel_green, pixel_blue
  input  logic [pcagq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // cell_column, cell_row, glyph_index, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
  output logic [pcagq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // has_background
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  pcagq_pkg::cmd_t cmd;
  pcagq_pkg::sts_t sts;

  pcagq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcagq_datapath #(
    .GLYPH_COUNT     (GLYPH_COUNT),
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
    .MAX_CELL_SIZE   (MAX_CELL_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .out_data_o   (m_axis_tdata),
    .out_has_bg_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== sim/pixel_cell_average_glyph_quantizer_test.sv =====
`timescale 1ns / 100ps

module pixel_cell_average_glyph_quantizer_test;

  localparam int unsigned GLYPHS = pcagq_pkg::GLYPH_COUNT_DEF;
  localparam int unsigned MAXW   = pcagq_pkg::MAX_FRAME_WIDTH_DEF;
  localparam int unsigned MAXC   = pcagq_pkg::MAX_CELL_SIZE_DEF;
  localparam int unsigned SETTLE = 64;
  localparam int unsigned ITEMS  = 1050;

  localparam int PAT_RANDOM  = 0;
  localparam int PAT_WHITE   = 1;
  localparam int PAT_CHECKER = 2;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  glyph;
    logic [7:0]  fg_r, fg_g, fg_b;
    logic [7:0]  bg_r, bg_g, bg_b;
    logic        has_bg;
    logic        frame_done;
  } cell_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [pcagq_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [pcagq_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // pixel_red, pixel_green, pixel_blue
  logic [pcagq_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // cell_column, cell_row, glyph_index, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
  logic [pcagq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // has_background
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  pixel_cell_average_glyph_quantizer dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [12:0] frame_w_reg, frame_h_reg;
  logic [4:0]  cell_w_reg, cell_h_reg;
  logic        colour_reg;
  int unsigned red_acc[MAXW], green_acc[MAXW], blue_acc[MAXW];
  int unsigned px_x, px_y, x_cell, y_cell, band;

  logic [23:0] pixel_q[$];
  cell_t       cells_due[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          sender_busy = 1'b0, receiver_busy = 1'b0;
  int          hold_req = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < MAXW; i++) begin
      red_acc[i] = 0;
      green_acc[i] = 0;
      blue_acc[i] = 0;
    end
    px_x = 0; px_y = 0; x_cell = 0; y_cell = 0; band = 0;
  endfunction

  function automatic void accumulate_pixel(logic [23:0] pix);
    int unsigned fw, fh, cw, ch, col, cnt, ar, ag, ab;
    bit ex, ey, lx, ly;
    longint unsigned y16, idx;
    cell_t c;
    fw = clampu(32'(frame_w_reg), 1, MAXW);
    fh = clampu(32'(frame_h_reg), 1, 4096);
    cw = clampu(32'(cell_w_reg), 1, MAXC);
    ch = clampu(32'(cell_h_reg), 1, MAXC);
    col = (px_x / cw) % MAXW;
    ex = px_x >= fw - 1;
    ey = px_y >= fh - 1;
    lx = (x_cell >= cw - 1) || ex;
    ly = (y_cell >= ch - 1) || ey;
    red_acc[col] += 32'(pix[7:0]);
    green_acc[col] += 32'(pix[15:8]);
    blue_acc[col] += 32'(pix[23:16]);
    if (lx && ly) begin
      cnt = (x_cell + 1) * (y_cell + 1);
      ar = red_acc[col] / cnt;
      ag = green_acc[col] / cnt;
      ab = blue_acc[col] / cnt;
      y16 = 64'd19595 * ar + 64'd38470 * ag + 64'd7471 * ab;
      idx = (y16 * 64'(GLYPHS - 1) + 64'd8355840) / 64'd16711680;
      if (idx > 64'(GLYPHS - 1)) idx = 64'(GLYPHS - 1);
      ar = clampu(ar, 0, 255);
      ag = clampu(ag, 0, 255);
      ab = clampu(ab, 0, 255);
      c.column = col[11:0];
      c.row = band[11:0];
      c.glyph = idx[7:0];
      if (colour_reg) begin
        c.fg_r = ar[7:0]; c.fg_g = ag[7:0]; c.fg_b = ab[7:0];
        c.bg_r = 8'(ar / 4); c.bg_g = 8'(ag / 4); c.bg_b = 8'(ab / 4);
        c.has_bg = 1'b1;
      end else begin
        c.fg_r = 8'hff; c.fg_g = 8'hff; c.fg_b = 8'hff;
        c.bg_r = 8'h00; c.bg_g = 8'h00; c.bg_b = 8'h00;
        c.has_bg = 1'b0;
      end
      c.frame_done = ex && ey;
      cells_due.push_back(c);
      red_acc[col] = 0; green_acc[col] = 0; blue_acc[col] = 0;
    end
    if (ex) begin
      px_x = 0;
      x_cell = 0;
      if (ey) begin
        px_y = 0; y_cell = 0; band = 0;
      end else begin
        px_y++;
        if (ly) begin
          y_cell = 0;
          band++;
        end else begin
          y_cell++;
        end
      end
    end else begin
      px_x++;
      x_cell = lx ? 0 : x_cell + 1;
    end
  endfunction

  // pixel driver
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic        nxt_valid;
    logic [23:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_pixel(s_axis_tdata);
        nxt_valid = 1'b0;
        send_gap = sender_busy ? 0 : $urandom_range(0, 13);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data = pixel_q.pop_front();
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata <= nxt_data;
    end
  end

  // cell monitor
  int recv_gap = 0, hold_cnt = 0, hold_seen = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cell_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[31:24],
               m_axis_tdata[39:32], m_axis_tdata[47:40], m_axis_tdata[55:48],
               m_axis_tdata[63:56], m_axis_tdata[71:64], m_axis_tdata[79:72],
               m_axis_tuser, m_axis_tlast};
        if (cells_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected cell item: %p", got);
        end else begin
          want = cells_due.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("cell mismatch: expected %p actual %p", want, got);
          end
        end
        recv_gap = receiver_busy ? 0 : $urandom_range(0, 13);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pixel_q.size() != 0 || s_axis_tvalid || cells_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pcagq_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[pcagq_pkg::CFG_DATA_W-1:0];
    case (idx)
      pcagq_pkg::REG_FRAME_WIDTH:  frame_w_reg = val[12:0];
      pcagq_pkg::REG_FRAME_HEIGHT: frame_h_reg = val[12:0];
      pcagq_pkg::REG_CELL_WIDTH:   cell_w_reg = val[4:0];
      pcagq_pkg::REG_CELL_HEIGHT:  cell_h_reg = val[4:0];
      pcagq_pkg::REG_COLOR_MODE:   colour_reg = val[0];
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic run_frame(int unsigned fw, int unsigned fh, int unsigned cw, int unsigned ch,
                           int unsigned cm, int npix, int pattern, bit hold);
    logic [23:0] p;
    wait_idle();
    write_reg(pcagq_pkg::REG_COLOR_MODE, cm);
    write_reg(pcagq_pkg::REG_CELL_HEIGHT, ch);
    write_reg(pcagq_pkg::REG_FRAME_WIDTH, fw);
    write_reg(pcagq_pkg::REG_CELL_WIDTH, cw);
    write_reg(pcagq_pkg::REG_FRAME_HEIGHT, fh);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sender_busy = ($urandom_range(0, 3) == 0);
    receiver_busy = ($urandom_range(0, 3) == 0);
    if (hold) begin
      sender_busy = 1'b1;
      hold_req++;
    end
    for (int i = 0; i < npix; i++) begin
      case (pattern)
        PAT_WHITE:   p = 24'hffffff;
        PAT_CHECKER: p = (i % 2) ? 24'hffffff : 24'h000000;
        default:     p = 24'($urandom());
      endcase
      pixel_q.push_back(p);
    end
    items_sent += npix;
  endtask

  initial begin
    int unsigned fw, fh, cw, ch;
    int n;
    frame_w_reg = pcagq_pkg::FRAME_WIDTH_RST;
    frame_h_reg = pcagq_pkg::FRAME_HEIGHT_RST;
    cell_w_reg = pcagq_pkg::CELL_WIDTH_RST;
    cell_h_reg = pcagq_pkg::CELL_HEIGHT_RST;
    colour_reg = 1'b1;
    restart_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // default geometry, a few pixels
    for (int i = 0; i < 5; i++) pixel_q.push_back(24'($urandom()));
    run_frame(4, 4, 2, 2, 1, 16, PAT_CHECKER, 0);
    run_frame(0, 0, 0, 0, 0, 3, PAT_RANDOM, 0);
    run_frame(8191, 8191, 31, 31, 1, 20, PAT_RANDOM, 0);
    run_frame(4096, 1, 16, 16, 1, 48, PAT_RANDOM, 0);
    run_frame(16, 16, 16, 16, 1, 256, PAT_WHITE, 0);
    run_frame(16, 4, 1, 1, 1, 64, PAT_RANDOM, 1);
    run_frame(5, 3, 2, 2, 0, 15, PAT_CHECKER, 0);
    while (items_sent < ITEMS) begin
      fw = $urandom_range(1, 24);
      fh = $urandom_range(1, 12);
      cw = $urandom_range(1, 16);
      ch = $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) begin
        cw = $urandom_range(1, 3);
        ch = $urandom_range(1, 3);
      end
      n = fw * fh * $urandom_range(1, 2) + $urandom_range(0, 1) * $urandom_range(0, 7);
      if (n > ITEMS - items_sent) n = ITEMS - items_sent;
      run_frame(fw, fh, cw, ch, $urandom_range(0, 1), n,
                ($urandom_range(0, 9) == 0) ? PAT_CHECKER : PAT_RANDOM, 0);
    end
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
